@@ rtl/thlm_pkg.sv @@
// ----------------------------------------------------------------------------
// thlm_pkg
// Shared widths, register indexes and types of the tree lock manager.
// ----------------------------------------------------------------------------
package thlm_pkg;

   localparam int NODE_W = 10;   // node index
   localparam int UID_W  = 32;   // user id
   localparam int NUM_W  = 11;   // num_nodes register
   localparam int BR_W   = 10;   // branching register
   localparam int CNT_W  = 11;   // locked-below count
   localparam int CSR_W  = 11;   // widest register
   localparam int SHF_W  = 4;    // shift amount for a power-of-two branching

   // register indexes
   localparam logic CSR_NUM_NODES = 1'b0;
   localparam logic CSR_BRANCHING = 1'b1;

   localparam logic ACT_UNLOCK = 1'b0;
   localparam logic ACT_LOCK   = 1'b1;

   typedef struct packed {
      logic              done;
      logic [NODE_W-1:0] quot;
   } div_rsp_type;

endpackage

@@ rtl/tree_hierarchical_lock_manager_unit.sv @@
// ----------------------------------------------------------------------------
// tree_hierarchical_lock_manager_unit
// Lock manager over an m-ary heap-ordered tree: lock/unlock with path checks.
// ----------------------------------------------------------------------------
// Request channel (req_*): action, node index and user id; one beat in gives
// one rsp_granted beat out. req_stall is high while a request is in work.
// A lock walks from the node to the root checking lock bits, then walks the
// path again bumping the locked-below counts. An unlock checks the owner at
// the node and walks the path once, taking the counts down.
// One tree level finds its parent by a shift when branching is a power of two
// and from the shared radix-2 divider otherwise; out-of-range requests skip
// the walk and are refused.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; if rsp_stall holds, the next result
// waits in its final state until the slot frees.
// After reset the lock/count store is swept to zero, one entry a cycle, with
// req_stall high; csr writes are taken at any time.
// ----------------------------------------------------------------------------
module tree_hierarchical_lock_manager_unit import thlm_pkg::*; #(
   parameter int MAX_NODES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [NODE_W-1:0] req_node_index,
   input  logic [UID_W-1:0]  req_user_id,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_granted,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_NODES);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [BR_W-1:0]     br_ff, br_in;
   logic                act_ff, act_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [UID_W-1:0]    uid_ff, uid_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic                adj_ff, adj_in;     // count-update walk
   logic                grant_ff, grant_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;

   // {held, count} per node, and owner per node
   logic [CNT_W:0]      st_mem [MAX_NODES];
   logic [UID_W-1:0]    own_mem [MAX_NODES];
   logic [CNT_W:0]      st_q_ff;
   logic [UID_W-1:0]    own_q_ff;
   logic                st_we, own_we;
   logic [AW-1:0]       st_waddr, rd_addr;
   logic [CNT_W:0]      st_wdata;

   logic [BR_W-1:0]     m_eff;
   logic                m_pow2;
   logic [SHF_W-1:0]    m_shift;
   logic [NODE_W-1:0]   cur_m1, fast_parent;
   logic                in_range;
   logic                held;
   logic [CNT_W-1:0]    cnt, cnt_up, cnt_dn;
   logic                at_node;
   logic                div_start;
   div_rsp_type         div_rsp;

   thlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cur_m1),
      .divisor  (m_eff),
      .rsp      (div_rsp)
   );

   // tree shape
   always_comb begin
      m_eff   = (br_ff == '0) ? BR_W'(1) : br_ff;
      m_pow2  = ((m_eff & (m_eff - 1'b1)) == '0);
      m_shift = '0;
      for (int b = 0; b < BR_W; b++) begin
         if (m_eff[b]) m_shift = m_shift | SHF_W'(b);
      end
   end

   assign cur_m1      = cur_ff - 1'b1;
   assign fast_parent = cur_m1 >> m_shift;
   assign in_range    = ({1'b0, req_node_index} < num_ff) &&
                        (32'(req_node_index) < MAX_NODES);

   assign held    = st_q_ff[CNT_W];
   assign cnt     = st_q_ff[CNT_W-1:0];
   assign cnt_up  = (cnt == '1) ? cnt : cnt + 1'b1;
   assign cnt_dn  = (cnt == '0) ? cnt : cnt - 1'b1;
   assign at_node = (cur_ff == node_ff);

   always_comb begin
      state_in       = state_ff;
      num_in         = num_ff;
      br_in          = br_ff;
      act_in         = act_ff;
      node_in        = node_ff;
      uid_in         = uid_ff;
      cur_in         = cur_ff;
      adj_in         = adj_ff;
      grant_in       = grant_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      st_we          = 1'b0;
      st_waddr       = AW'(cur_ff);
      st_wdata       = '0;
      own_we         = 1'b0;
      div_start      = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_NODES: num_in = csr_wdata[NUM_W-1:0];
            CSR_BRANCHING: br_in  = csr_wdata[BR_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_NODES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               node_in  = req_node_index;
               uid_in   = req_user_id;
               cur_in   = req_node_index;
               adj_in   = (req_action == ACT_UNLOCK);
               grant_in = 1'b0;
               state_in = in_range ? S_EVAL : S_DONE;
            end
         end
         S_EVAL: begin
            // st_q_ff / own_q_ff hold entry cur_ff here
            if (!adj_ff) begin
               if (held || (at_node && cnt != '0)) begin
                  state_in = S_DONE;
               end else if (cur_ff == '0) begin
                  adj_in = 1'b1;
                  cur_in = node_ff;
               end else if (m_pow2) begin
                  cur_in = fast_parent;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else if (act_ff == ACT_UNLOCK && at_node &&
                         !(held && own_q_ff == uid_ff)) begin
               state_in = S_DONE;
            end else begin
               st_we = 1'b1;
               if (act_ff == ACT_LOCK) begin
                  st_wdata = {held | at_node, cnt_up};
                  own_we   = at_node;
               end else begin
                  st_wdata = {held & ~at_node, cnt_dn};
               end
               if (cur_ff == '0) begin
                  grant_in = 1'b1;
                  state_in = S_DONE;
               end else if (m_pow2) begin
                  cur_in = fast_parent;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               cur_in   = div_rsp.quot;
               state_in = S_EVAL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = grant_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // read follows the next walk position, so data lines up with cur_ff
   assign rd_addr = AW'(cur_in);

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_waddr] <= st_wdata;
      st_q_ff <= st_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (own_we) own_mem[AW'(cur_ff)] <= uid_ff;
      own_q_ff <= own_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         num_ff       <= NUM_W'(1024);
         br_ff        <= BR_W'(2);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         adj_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         br_ff        <= br_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
      end
      act_ff         <= act_in;
      node_ff        <= node_in;
      uid_ff         <= uid_in;
      cur_ff         <= cur_in;
      grant_ff       <= grant_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;

   // walk never leaves the path between the node and the root
   a_walk_on_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (cur_ff <= node_ff))
      else $error("walk position above requested node");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside parent wait");

   a_div_start_slow: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (!m_pow2 && cur_ff != '0))
      else $error("divider started for shift-able branching or root");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      st_we |-> (state_ff == S_CLEAR || (state_ff == S_EVAL && adj_ff)))
      else $error("store written outside clear or count walk");

endmodule

@@ rtl/thlm_div.sv @@
// ----------------------------------------------------------------------------
// thlm_div
// Restoring divider, one quotient bit a cycle; gives the parent index.
// ----------------------------------------------------------------------------
module thlm_div import thlm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NODE_W-1:0] dividend,
   input  logic [BR_W-1:0]   divisor,
   output div_rsp_type       rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SHF_W-1:0]    cnt_ff, cnt_in;
   logic [BR_W-1:0]     rem_ff, rem_in;
   logic [NODE_W-1:0]   quo_ff, quo_in;
   logic [BR_W-1:0]     dvs_ff, dvs_in;
   logic [BR_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[NODE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = BR_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[NODE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BR_W-1:0];
            quo_in = {quo_ff[NODE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SHF_W'(NODE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

@@ tb/tree_hierarchical_lock_manager_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_hierarchical_lock_manager_unit_tb
// Checks lock/unlock grants of the tree lock manager. A table of directed
// requests and tree shapes comes first, then random request streams over
// several tree shapes. Every grant is compared against a behavioral copy of
// the lock, owner and locked-below stores, or against the fixed expectation
// of a directed row, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tree_hierarchical_lock_manager_unit_tb;
   import thlm_pkg::*;

   localparam int TREE_NODES = 1024;
   localparam logic [CNT_W-1:0] COUNT_TOP = '1;
   localparam int NUM_PHASES = 11;

   typedef enum logic [1:0] {EXP_PREDICT, EXP_REFUSE, EXP_GRANT} exp_kind_type;
   typedef enum logic {ROW_REQ, ROW_SHAPE} row_kind_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              action;
      logic [NODE_W-1:0] node;
      logic [UID_W-1:0]  uid;
      exp_kind_type      exp;
      logic [NUM_W-1:0]  num;
      logic [BR_W-1:0]   br;
   } dir_row_type;

   typedef struct packed {
      logic              granted;
      logic              action;
      logic [NODE_W-1:0] node;
   } grant_due_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_action;
   logic [NODE_W-1:0] req_node_index;
   logic [UID_W-1:0]  req_user_id;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_granted;
   logic              csr_we;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   // behavioral copy of the block
   logic [NUM_W-1:0] cfg_num_nodes;
   logic [BR_W-1:0]  cfg_branching;
   bit               node_locked   [TREE_NODES];
   logic [UID_W-1:0] node_owner    [TREE_NODES];
   logic [CNT_W-1:0] subtree_locks [TREE_NODES];

   grant_due_type    grants_due[$];
   logic [UID_W-1:0] user_pool[4];

   int send_idle_pct;
   int stall_pct;
   int mismatches;
   int requests_sent;
   int grants_seen;
   int shapes_set;

   int phase_num   [NUM_PHASES] = '{1024, 1, 64, 1024, 16, 1024, 200, 2047, 40, 0, 1024};
   int phase_br    [NUM_PHASES] = '{2, 1, 3, 1023, 0, 4, 7, 5, 1, 2, 2};
   int phase_items [NUM_PHASES] = '{100, 30, 90, 80, 60, 90, 80, 80, 60, 20, 40};

   tree_hierarchical_lock_manager_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_node_index (req_node_index),
      .req_user_id    (req_user_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // grant predictor
   // ---------------------------------------------------------------------
   function automatic int nodes_live();
      return (cfg_num_nodes > TREE_NODES) ? TREE_NODES : int'(cfg_num_nodes);
   endfunction

   function automatic int parent_node(int i);
      int m;
      m = (cfg_branching == 0) ? 1 : int'(cfg_branching);
      return (i - 1) / m;
   endfunction

   function automatic bit path_locked(int i);
      int n;
      bit hit;
      bit done;
      n = i;
      hit = 1'b0;
      done = 1'b0;
      while (!done) begin
         if (node_locked[n]) begin
            hit = 1'b1;
            done = 1'b1;
         end else if (n == 0) begin
            done = 1'b1;
         end else begin
            n = parent_node(n);
         end
      end
      return hit;
   endfunction

   // counts saturate on the way up and floor at zero on the way down
   function automatic void bump_path(int i, bit up);
      int n;
      bit done;
      n = i;
      done = 1'b0;
      while (!done) begin
         if (up) begin
            if (subtree_locks[n] != COUNT_TOP) subtree_locks[n] = subtree_locks[n] + 1'b1;
         end else if (subtree_locks[n] != 0) begin
            subtree_locks[n] = subtree_locks[n] - 1'b1;
         end
         if (n == 0) done = 1'b1;
         else n = parent_node(n);
      end
   endfunction

   function automatic bit tree_grant(logic action, int node, logic [UID_W-1:0] uid);
      bit ok;
      ok = 1'b0;
      if (node < nodes_live()) begin
         if (action == ACT_LOCK) begin
            if (!path_locked(node) && subtree_locks[node] == 0) begin
               node_locked[node] = 1'b1;
               node_owner[node] = uid;
               bump_path(node, 1'b1);
               ok = 1'b1;
            end
         end else if (node_locked[node] && node_owner[node] == uid) begin
            node_locked[node] = 1'b0;
            bump_path(node, 1'b0);
            ok = 1'b1;
         end
      end
      return ok;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic dir_row_type req_row(logic action, logic [NODE_W-1:0] node,
                                           logic [UID_W-1:0] uid, exp_kind_type exp);
      dir_row_type row;
      row.kind = ROW_REQ;
      row.action = action;
      row.node = node;
      row.uid = uid;
      row.exp = exp;
      row.num = '0;
      row.br = '0;
      return row;
   endfunction

   function automatic dir_row_type shape_row(logic [NUM_W-1:0] num, logic [BR_W-1:0] br);
      dir_row_type row;
      row = req_row(ACT_UNLOCK, '0, '0, EXP_PREDICT);
      row.kind = ROW_SHAPE;
      row.num = num;
      row.br = br;
      return row;
   endfunction

   task automatic set_idling(idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 50 : (mode == IDLE_BOTH) ? 7 : 0;
      stall_pct     = (mode == IDLE_RECEIVER) ? 50 : (mode == IDLE_BOTH) ? 7 : 0;
   endtask

   // called at a clock edge; returns at the edge where the beat is taken
   task automatic send_request(logic action, logic [NODE_W-1:0] node,
                               logic [UID_W-1:0] uid, exp_kind_type exp);
      grant_due_type due;
      bit model_ok;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_node_index <= node;
      req_user_id    <= uid;
      do @(posedge clock); while (req_stall);
      model_ok = tree_grant(action, int'(node), uid);
      due.granted = (exp == EXP_PREDICT) ? model_ok : (exp == EXP_GRANT);
      due.action = action;
      due.node = node;
      grants_due = {grants_due, due};
      requests_sent++;
      if (due.granted) grants_seen++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_shape(logic [NUM_W-1:0] num, logic [BR_W-1:0] br);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_NODES;
      csr_wdata <= num;
      @(posedge clock);
      csr_index <= CSR_BRANCHING;
      csr_wdata <= CSR_W'(br);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_num_nodes = num;
      cfg_branching = br;
      shapes_set++;
   endtask

   // mostly unlocks of held nodes by their owner and locks inside the tree;
   // the rest is noise over the whole index range
   task automatic send_random();
      int live;
      int held_cnt;
      int pick;
      int target;
      int r;
      int i;
      logic [UID_W-1:0] uid;
      logic [NODE_W-1:0] node;
      logic action;
      live = nodes_live();
      r = $urandom_range(99);
      uid = ($urandom_range(3) == 0) ? $urandom() : user_pool[$urandom_range(3)];
      held_cnt = 0;
      for (i = 0; i < live; i++)
         if (node_locked[i]) held_cnt++;
      if (r < 40 && held_cnt > 0) begin
         pick = $urandom_range(held_cnt - 1);
         target = -1;
         for (i = 0; i < live; i++)
            if (node_locked[i] && target < 0) begin
               if (pick == 0) target = i;
               pick--;
            end
         uid = node_owner[target];
         if ($urandom_range(9) == 0) uid = uid ^ (32'd1 << $urandom_range(31));
         node = target[NODE_W-1:0];
         send_request(ACT_UNLOCK, node, uid, EXP_PREDICT);
      end else if (r < 88 && live > 0) begin
         node = NODE_W'($urandom_range(live - 1));
         send_request(ACT_LOCK, node, uid, EXP_PREDICT);
      end else begin
         action = 1'($urandom_range(1));
         node = NODE_W'($urandom_range(TREE_NODES - 1));
         send_request(action, node, $urandom(), EXP_PREDICT);
      end
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : grant_check
      grant_due_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grants_due.size() == 0) begin
            $error("granted: expected nothing, actual %0d", rsp_granted);
            mismatches++;
         end else begin
            due = grants_due.pop_front();
            if (rsp_granted !== due.granted) begin
               $error("granted: expected %0d, actual %0d (action %0d, node %0d)",
                      due.granted, rsp_granted, due.action, due.node);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type rows[$];
      int p;
      int k;
      logic [UID_W-1:0] u_max;
      logic [UID_W-1:0] u_min;
      logic [UID_W-1:0] u_neg;
      logic [UID_W-1:0] u_zero;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_UNLOCK;
      req_node_index <= '0;
      req_user_id    <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_NUM_NODES;
      csr_wdata      <= '0;

      send_idle_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      requests_sent = 0;
      grants_seen = 0;
      shapes_set = 1;
      cfg_num_nodes = NUM_W'(TREE_NODES);
      cfg_branching = BR_W'(2);
      for (k = 0; k < TREE_NODES; k++) begin
         node_locked[k] = 1'b0;
         node_owner[k] = '0;
         subtree_locks[k] = '0;
      end

      u_max  = 32'h7fff_ffff;
      u_min  = 32'h8000_0000;
      u_neg  = 32'hffff_ffff;
      u_zero = 32'h0000_0000;
      user_pool[0] = u_zero;
      user_pool[1] = u_neg;
      user_pool[2] = u_max;
      user_pool[3] = u_min;

      // reset shape: binary tree of 1024 nodes
      rows = {rows, req_row(ACT_LOCK,   10'd0,    u_max,  EXP_GRANT)};
      rows = {rows, req_row(ACT_LOCK,   10'd1023, u_min,  EXP_REFUSE)}; // root held
      rows = {rows, req_row(ACT_UNLOCK, 10'd0,    u_zero, EXP_REFUSE)}; // other owner
      rows = {rows, req_row(ACT_UNLOCK, 10'd0,    u_max,  EXP_GRANT)};
      rows = {rows, req_row(ACT_LOCK,   10'd1023, u_min,  EXP_GRANT)};
      rows = {rows, req_row(ACT_LOCK,   10'd0,    u_zero, EXP_REFUSE)}; // leaf held below
      rows = {rows, req_row(ACT_UNLOCK, 10'd1023, u_min,  EXP_GRANT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd1023, u_min,  EXP_REFUSE)}; // not held
      rows = {rows, shape_row(11'd5, 10'd2)};
      rows = {rows, req_row(ACT_LOCK,   10'd5,    u_neg,  EXP_REFUSE)}; // out of range
      rows = {rows, req_row(ACT_LOCK,   10'd4,    u_neg,  EXP_GRANT)};
      rows = {rows, shape_row(11'd0, 10'd2)};
      rows = {rows, req_row(ACT_LOCK,   10'd0,    u_max,  EXP_REFUSE)}; // empty tree
      rows = {rows, req_row(ACT_UNLOCK, 10'd4,    u_neg,  EXP_REFUSE)};
      // oversized node count, zero branching: one long chain, lock on node 4 kept
      rows = {rows, shape_row(11'd2047, 10'd0)};
      rows = {rows, req_row(ACT_LOCK,   10'd1023, u_min,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd4,    u_neg,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_LOCK,   10'd1023, u_min,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_LOCK,   10'd0,    u_max,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd1023, u_min,  EXP_PREDICT)};
      rows = {rows, shape_row(11'd1024, 10'd1023)};
      rows = {rows, req_row(ACT_LOCK,   10'd1023, u_zero, EXP_PREDICT)};
      rows = {rows, req_row(ACT_LOCK,   10'd1,    u_zero, EXP_PREDICT)};
      rows = {rows, req_row(ACT_LOCK,   10'd0,    u_max,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd1023, u_zero, EXP_PREDICT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd1,    u_max,  EXP_PREDICT)};
      rows = {rows, shape_row(11'd1024, 10'd3)};
      rows = {rows, req_row(ACT_LOCK,   10'd13,   u_max,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_LOCK,   10'd4,    u_min,  EXP_PREDICT)};
      rows = {rows, req_row(ACT_UNLOCK, 10'd13,   u_max,  EXP_PREDICT)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < rows.size(); k++) begin
         set_idling(idle_mode_type'((k / 7) % 4));
         if (rows[k].kind == ROW_SHAPE) begin
            wait_drained();
            write_shape(rows[k].num, rows[k].br);
         end else begin
            send_request(rows[k].action, rows[k].node, rows[k].uid, rows[k].exp);
         end
      end

      // locks left over from one shape stay held into the next
      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_shape(NUM_W'(phase_num[p]), BR_W'(phase_br[p]));
         for (k = 0; k < phase_items[p]; k++) begin
            if (k % 30 == 0) set_idling(idle_mode_type'((p + k / 30) % 4));
            send_random();
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);

      $display("Ran %0d lock/unlock requests, %0d granted, over %0d tree shapes",
               requests_sent, grants_seen, shapes_set);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/thlm_pkg.sv
rtl/thlm_div.sv
rtl/tree_hierarchical_lock_manager_unit.sv
tb/tree_hierarchical_lock_manager_unit_tb.sv
